// ===== sv/lbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbrs_pkg
// Shared types, constants and CRC-32 helpers for the boot record scanner.
// ----------------------------------------------------------------------------
package lbrs_pkg;

    // log record constants
    localparam logic [31:0] LOG_MAGIC   = 32'h4154_4D43;
    localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;
    localparam logic [7:0]  SLOT_A      = 8'h41;
    localparam logic [7:0]  SLOT_B      = 8'h42;

    // crc-32 constants, reflected form
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_XOROUT = 32'hFFFF_FFFF;
    localparam int          CRC_BYTES = 12;
    localparam int          CRC_BITS  = CRC_BYTES * 8;

    // page size default and port widths
    localparam int RECORDS_PER_PAGE_DEF = 256;
    localparam int FREE_INDEX_W         = 9;
    localparam int S_TDATA_W            = 128;
    localparam int M_TDATA_W            = 48;

    // one log record, magic in the lowest bits
    typedef struct packed {
        logic [31:0] crc;
        logic [31:0] slot_word;
        logic [31:0] sequence_num;
        logic [31:0] magic;
    } record_t;

    // outcome of the per-record checks
    typedef struct packed {
        logic erased;
        logic valid;
        logic slot_b;
    } rec_check_t;

    // one result item, found in the lowest bit
    typedef struct packed {
        logic                    log_full;
        logic [FREE_INDEX_W-1:0] free_index;
        logic                    scan_stopped;
        logic                    record_accepted;
        logic [31:0]             lead_sequence;
        logic                    lead_slot;
        logic                    found;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

    // bit-serial reflected crc, evaluated at elaboration only
    function automatic logic [31:0] crc_raw(logic [31:0] init, logic [CRC_BITS-1:0] data);
        logic [31:0] c;
        logic        fb;
        c = init;
        for (int i = 0; i < CRC_BITS; i++) begin
            fb = c[0] ^ data[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    // contribution of each message bit with zero preset
    function automatic logic [CRC_BITS-1:0][31:0] crc_columns();
        logic [CRC_BITS-1:0][31:0] cols;
        for (int i = 0; i < CRC_BITS; i++) begin
            cols[i] = crc_raw(32'h0, CRC_BITS'(1) << i);
        end
        return cols;
    endfunction

    // crc of an all-zero message including preset and final inversion
    localparam logic [31:0]               CRC_ZERO = crc_raw(CRC_INIT, '0) ^ CRC_XOROUT;
    localparam logic [CRC_BITS-1:0][31:0] CRC_COLS = crc_columns();

    // parallel crc: xor of the columns selected by the message bits
    function automatic logic [31:0] crc_parallel(logic [CRC_BITS-1:0] data);
        logic [31:0] c;
        c = CRC_ZERO;
        for (int i = 0; i < CRC_BITS; i++) begin
            if (data[i]) begin
                c = c ^ CRC_COLS[i];
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/lbrs_rec_check.sv =====
// ----------------------------------------------------------------------------
// lbrs_rec_check
// Combinational magic, crc and slot checks on one registered log record.
// ----------------------------------------------------------------------------
module lbrs_rec_check (
    input  lbrs_pkg::record_t    rec,
    output lbrs_pkg::rec_check_t chk
);

    logic [31:0] crc_calc;
    logic [7:0]  slot_byte;
    logic        slot_ok;

    // crc over magic, sequence and slot words, little-endian byte order
    assign crc_calc  = lbrs_pkg::crc_parallel({rec.slot_word, rec.sequence_num, rec.magic});
    assign slot_byte = rec.slot_word[7:0];
    assign slot_ok   = (slot_byte == lbrs_pkg::SLOT_A) || (slot_byte == lbrs_pkg::SLOT_B);

    // check outcome
    always_comb begin
        chk.erased = (rec.magic == lbrs_pkg::ERASED_WORD);
        chk.valid  = (rec.magic == lbrs_pkg::LOG_MAGIC) && (crc_calc == rec.crc) && slot_ok;
        chk.slot_b = (slot_byte == lbrs_pkg::SLOT_B);
    end

endmodule

// ===== sv/lbrs_scan_core.sv =====
// ----------------------------------------------------------------------------
// lbrs_scan_core
// Scan state registers and result register, updated once per record.
// ----------------------------------------------------------------------------
module lbrs_scan_core #(
    parameter int RECORDS_PER_PAGE = lbrs_pkg::RECORDS_PER_PAGE_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  logic                 start_scan,
    input  logic [31:0]          rec_sequence,
    input  lbrs_pkg::rec_check_t chk,
    output lbrs_pkg::result_t    result
);

    localparam int IDX_W = $clog2(RECORDS_PER_PAGE + 1);
    localparam logic [IDX_W-1:0] PAGE_END = IDX_W'(RECORDS_PER_PAGE);

    logic             stopped_reg, stopped_next;
    logic             found_reg, found_next;
    logic [31:0]      lead_seq_reg, lead_seq_next;
    logic             lead_slot_reg, lead_slot_next;
    logic [IDX_W-1:0] index_reg, index_next;
    lbrs_pkg::result_t result_reg, result_next;

    logic             cur_stopped;
    logic             cur_found;
    logic [31:0]      cur_seq;
    logic             cur_slot;
    logic [IDX_W-1:0] cur_index;
    logic             active;
    logic             accepted;

    // start flag clears the scan before this record is handled
    always_comb begin
        cur_stopped = start_scan ? 1'b0 : stopped_reg;
        cur_found   = start_scan ? 1'b0 : found_reg;
        cur_seq     = start_scan ? 32'h0 : lead_seq_reg;
        cur_slot    = start_scan ? 1'b0 : lead_slot_reg;
        cur_index   = start_scan ? '0 : index_reg;
    end

    // scan step
    always_comb begin
        active         = !cur_stopped && (cur_index < PAGE_END);
        accepted       = 1'b0;
        stopped_next   = cur_stopped;
        found_next     = cur_found;
        lead_seq_next  = cur_seq;
        lead_slot_next = cur_slot;
        index_next     = cur_index;
        if (active) begin
            if (chk.erased) begin
                stopped_next = 1'b1;
            end else begin
                if (chk.valid) begin
                    accepted = 1'b1;
                    if (!cur_found || (rec_sequence > cur_seq)) begin
                        found_next     = 1'b1;
                        lead_seq_next  = rec_sequence;
                        lead_slot_next = chk.slot_b;
                    end
                end
                index_next = cur_index + IDX_W'(1);
            end
        end
    end

    // result item from the updated state
    always_comb begin
        result_next.found           = found_next;
        result_next.lead_slot       = lead_slot_next;
        result_next.lead_sequence   = lead_seq_next;
        result_next.record_accepted = accepted;
        result_next.scan_stopped    = stopped_next;
        result_next.free_index      = lbrs_pkg::FREE_INDEX_W'(index_next);
        result_next.log_full        = !stopped_next && (index_next >= PAGE_END);
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stopped_reg   <= 1'b0;
            found_reg     <= 1'b0;
            lead_seq_reg  <= 32'h0;
            lead_slot_reg <= 1'b0;
            index_reg     <= '0;
        end else if (advance) begin
            stopped_reg   <= stopped_next;
            found_reg     <= found_next;
            lead_seq_reg  <= lead_seq_next;
            lead_slot_reg <= lead_slot_next;
            index_reg     <= index_next;
        end
    end

    // result payload register
    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

// ===== sv/latest_boot_record_scanner.sv =====
// ----------------------------------------------------------------------------
// latest_boot_record_scanner
// Scans a flash metadata log and keeps the latest valid boot record.
// ----------------------------------------------------------------------------
// A record passes through the input register, then the result register
// behind the combinational crc and checks. Throughput: one record per
// cycle while the receiver takes results. Reset: aresetn low at a clock
// edge clears the scan state and the valid flags of both stages.
module latest_boot_record_scanner #(
    parameter int RECORDS_PER_PAGE = lbrs_pkg::RECORDS_PER_PAGE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // slave side
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rec_magic, rec_sequence, rec_slot_word, rec_crc
    input  logic [lbrs_pkg::S_TDATA_W-1:0] s_tdata,
    // start_scan
    input  logic                           s_tuser,
    // master side
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // found, lead_slot, lead_sequence, record_accepted, scan_stopped,
    // free_index, log_full, zero pad
    output logic [lbrs_pkg::M_TDATA_W-1:0] m_tdata
);

    logic              in_valid_reg;
    lbrs_pkg::record_t in_rec_reg;
    logic              in_start_reg;
    logic              out_valid_reg;
    logic              advance;

    lbrs_pkg::rec_check_t chk;
    lbrs_pkg::result_t    result;

    // item moves from input register to result register
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_rec_reg   <= lbrs_pkg::record_t'(s_tdata);
            in_start_reg <= s_tuser;
        end
    end

    // result stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    lbrs_rec_check u_check (
        .rec (in_rec_reg),
        .chk (chk)
    );

    lbrs_scan_core #(
        .RECORDS_PER_PAGE (RECORDS_PER_PAGE)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .start_scan   (in_start_reg),
        .rec_sequence (in_rec_reg.sequence_num),
        .chk          (chk),
        .result       (result)
    );

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = lbrs_pkg::M_TDATA_W'(result);

endmodule

// ===== sv/lbrs_checker.sv =====
// ----------------------------------------------------------------------------
// lbrs_checker
// Port-level checks on the result stream of the boot record scanner.
// ----------------------------------------------------------------------------
module lbrs_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lbrs_pkg::M_TDATA_W-1:0] m_tdata
);

    logic found;
    logic accepted;
    logic stopped;
    logic full;

    assign found    = m_tdata[0];
    assign accepted = m_tdata[34];
    assign stopped  = m_tdata[35];
    assign full     = m_tdata[45];

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an accepted record always leaves a best record
    a_accept_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && accepted |-> found)
        else $error("record accepted without best record");

    // no record is accepted once the scan has stopped
    a_accept_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && accepted |-> !stopped)
        else $error("record accepted on stopped scan");

    // a stopped scan never reports a full log
    a_stop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(stopped && full))
        else $error("stopped and full at once");

endmodule

bind latest_boot_record_scanner lbrs_checker u_lbrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_latest_boot_record_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_latest_boot_record_scanner
// Self-checking bench for the boot record log scanner. A directed pass walks
// the accept, reject, tie, erased-stop and restart cases; random scans of
// mostly well-formed records with some corrupt ones and noise follow, over
// phases of sender idling and receiver stalls. Every result transfer is
// compared field by field against an in-bench model of the scan state.
// ----------------------------------------------------------------------------
module tb_latest_boot_record_scanner;

    localparam int PAGE_RECORDS = lbrs_pkg::RECORDS_PER_PAGE_DEF;

    // tracks the scan state and holds the results still due from the block
    class boot_scan_tracker;
        bit                 stopped;
        bit                 found;
        bit [31:0]          lead_seq;
        bit                 lead_is_b;
        int unsigned        scanned;
        lbrs_pkg::result_t  due_results[$];
        int unsigned        errors;

        function new();
            clear_scan();
            errors = 0;
        endfunction

        function void clear_scan();
            stopped   = 1'b0;
            found     = 1'b0;
            lead_seq  = '0;
            lead_is_b = 1'b0;
            scanned   = 0;
        endfunction

        // reflected crc-32 over magic, sequence and slot word, bytes lsb first
        static function bit [31:0] log_crc(bit [31:0] magic, bit [31:0] seq,
                                           bit [31:0] slot_word);
            bit [95:0] msg;
            bit [31:0] c;
            msg = {slot_word, seq, magic};
            c   = lbrs_pkg::CRC_INIT;
            for (int i = 0; i < lbrs_pkg::CRC_BYTES; i++) begin
                c = c ^ {24'h0, msg[8*i +: 8]};
                for (int k = 0; k < 8; k++) begin
                    c = c[0] ? ((c >> 1) ^ lbrs_pkg::CRC_POLY) : (c >> 1);
                end
            end
            return c ^ lbrs_pkg::CRC_XOROUT;
        endfunction

        // advance the scan by one accepted record and queue its result
        function void note_record(bit start, lbrs_pkg::record_t rec);
            lbrs_pkg::result_t want;
            bit                ok;
            bit [7:0]          slot_byte;
            if (start) begin
                clear_scan();
            end
            ok        = 1'b0;
            slot_byte = rec.slot_word[7:0];
            if (!stopped && scanned < PAGE_RECORDS) begin
                if (rec.magic == lbrs_pkg::ERASED_WORD) begin
                    stopped = 1'b1;
                end else begin
                    ok = (rec.magic == lbrs_pkg::LOG_MAGIC) &&
                         (log_crc(rec.magic, rec.sequence_num, rec.slot_word) == rec.crc) &&
                         (slot_byte == lbrs_pkg::SLOT_A || slot_byte == lbrs_pkg::SLOT_B);
                    if (ok && (!found || rec.sequence_num > lead_seq)) begin
                        found     = 1'b1;
                        lead_seq  = rec.sequence_num;
                        lead_is_b = (slot_byte == lbrs_pkg::SLOT_B);
                    end
                    scanned++;
                end
            end
            want.found           = found;
            want.lead_slot       = lead_is_b;
            want.lead_sequence   = lead_seq;
            want.record_accepted = ok;
            want.scan_stopped    = stopped;
            want.free_index      = lbrs_pkg::FREE_INDEX_W'(scanned);
            want.log_full        = !stopped && scanned >= PAGE_RECORDS;
            due_results.push_back(want);
        endfunction

        // compare one result transfer with the oldest due result
        function void check_result(logic [lbrs_pkg::M_TDATA_W-1:0] data);
            lbrs_pkg::result_t got;
            lbrs_pkg::result_t want;
            got = data[lbrs_pkg::RESULT_W-1:0];
            if (due_results.size() == 0) begin
                $error("result transfer with none due: %h", data);
                errors++;
                return;
            end
            want = due_results.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, got %0d", want.found, got.found);
                errors++;
            end
            if (got.lead_slot !== want.lead_slot) begin
                $error("lead_slot: expected %0d, got %0d", want.lead_slot, got.lead_slot);
                errors++;
            end
            if (got.lead_sequence !== want.lead_sequence) begin
                $error("lead_sequence: expected %h, got %h",
                       want.lead_sequence, got.lead_sequence);
                errors++;
            end
            if (got.record_accepted !== want.record_accepted) begin
                $error("record_accepted: expected %0d, got %0d",
                       want.record_accepted, got.record_accepted);
                errors++;
            end
            if (got.scan_stopped !== want.scan_stopped) begin
                $error("scan_stopped: expected %0d, got %0d",
                       want.scan_stopped, got.scan_stopped);
                errors++;
            end
            if (got.free_index !== want.free_index) begin
                $error("free_index: expected %0d, got %0d", want.free_index, got.free_index);
                errors++;
            end
            if (got.log_full !== want.log_full) begin
                $error("log_full: expected %0d, got %0d", want.log_full, got.log_full);
                errors++;
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [lbrs_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                           s_tuser  = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [lbrs_pkg::M_TDATA_W-1:0] m_tdata;

    boot_scan_tracker scan_board = new();

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned hold_off_req       = 0;
    int unsigned hold_left          = 0;
    int unsigned items_sent         = 0;

    latest_boot_record_scanner #(
        .RECORDS_PER_PAGE(PAGE_RECORDS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // run limit
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge aclk) begin
        if (hold_off_req != 0) begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // watch both channels for transfers
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            scan_board.note_record(s_tuser, lbrs_pkg::record_t'(s_tdata));
        end
        if (aresetn && m_tvalid && m_tready) begin
            scan_board.check_result(m_tdata);
        end
    end

    function automatic lbrs_pkg::record_t build_record(bit [31:0] magic, bit [31:0] seq,
                                                       bit [31:0] slot_word);
        lbrs_pkg::record_t rec;
        rec.magic        = magic;
        rec.sequence_num = seq;
        rec.slot_word    = slot_word;
        rec.crc          = boot_scan_tracker::log_crc(magic, seq, slot_word);
        return rec;
    endfunction

    // mix of wide values, small values that tie, and the extremes
    function automatic bit [31:0] pick_sequence();
        case ($urandom_range(3))
            0: return $urandom_range(0, 15);
            1: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [31:0] pick_slot_word();
        bit [7:0] slot_byte;
        slot_byte = $urandom_range(1) ? lbrs_pkg::SLOT_B : lbrs_pkg::SLOT_A;
        return {($urandom_range(1) ? 24'($urandom) : 24'h0), slot_byte};
    endfunction

    // mostly good records, some corrupt ones and some noise
    function automatic lbrs_pkg::record_t random_record();
        lbrs_pkg::record_t rec;
        int unsigned       pick;
        bit [7:0]          slot_byte;
        pick = $urandom_range(99);
        rec  = build_record(lbrs_pkg::LOG_MAGIC, pick_sequence(), pick_slot_word());
        if (pick >= 70 && pick < 78) begin
            // stored crc off by one bit
            rec.crc = rec.crc ^ (32'h1 << $urandom_range(31));
        end else if (pick >= 78 && pick < 85) begin
            // slot byte neither A nor B
            slot_byte = 8'($urandom_range(255));
            if (slot_byte == lbrs_pkg::SLOT_A || slot_byte == lbrs_pkg::SLOT_B) begin
                slot_byte = slot_byte ^ 8'h80;
            end
            rec = build_record(lbrs_pkg::LOG_MAGIC, rec.sequence_num,
                               {24'($urandom), slot_byte});
        end else if (pick >= 85 && pick < 92) begin
            // foreign magic with a consistent crc
            rec.magic = $urandom;
            if (rec.magic == lbrs_pkg::LOG_MAGIC || rec.magic == lbrs_pkg::ERASED_WORD) begin
                rec.magic = rec.magic ^ 32'h1;
            end
            rec = build_record(rec.magic, rec.sequence_num, rec.slot_word);
        end else if (pick >= 92) begin
            rec = {$urandom, $urandom, $urandom, $urandom};
        end
        return rec;
    endfunction

    function automatic lbrs_pkg::record_t erased_record();
        lbrs_pkg::record_t rec;
        rec       = {$urandom, $urandom, $urandom, $urandom};
        rec.magic = lbrs_pkg::ERASED_WORD;
        return rec;
    endfunction

    // offer one record and hold it until the block takes it
    task automatic send_record(input bit start, input lbrs_pkg::record_t rec);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rec;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // stop offering until every due result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (scan_board.pending() != 0);
    endtask

    // one scan: a start record, a body, and optionally an erased record
    task automatic send_scan(input int unsigned len, input bit end_erased);
        int unsigned tail;
        send_record(1'b1, random_record());
        for (int unsigned k = 1; k < len; k++) begin
            send_record($urandom_range(99) < 3, random_record());
        end
        if (end_erased) begin
            send_record(1'b0, erased_record());
            tail = $urandom_range(0, 3);
            repeat (tail) send_record(1'b0, random_record());
        end
    endtask

    task automatic send_random_scans(input int unsigned phase_items, input bit long_first);
        int unsigned phase_end;
        int unsigned r;
        int unsigned len;
        phase_end = items_sent + phase_items;
        if (long_first) begin
            send_scan(PAGE_RECORDS + $urandom_range(0, 12), $urandom_range(1) == 1);
        end
        while (items_sent < phase_end) begin
            r = $urandom_range(99);
            if (r < 80) begin
                len = $urandom_range(1, 30);
            end else if (r < 96) begin
                len = $urandom_range(31, 100);
            end else begin
                len = $urandom_range(PAGE_RECORDS - 6, PAGE_RECORDS + 40);
            end
            send_scan(len, $urandom_range(99) < 60);
        end
    endtask

    task automatic run_directed();
        lbrs_pkg::record_t rec;
        // first scan after reset, no start flag
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd5, {24'h0, lbrs_pkg::SLOT_A}));
        // equal sequence does not replace
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd5, {24'h0, lbrs_pkg::SLOT_B}));
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd6, {24'h0, lbrs_pkg::SLOT_B}));
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd0, {24'h0, lbrs_pkg::SLOT_A}));
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'hFFFF_FFFF,
                                       {24'h0, lbrs_pkg::SLOT_A}));
        // bad crc, bad magic, bad slot
        rec     = build_record(lbrs_pkg::LOG_MAGIC, 32'd9, {24'h0, lbrs_pkg::SLOT_B});
        rec.crc = rec.crc ^ 32'h8000_0000;
        send_record(1'b0, rec);
        send_record(1'b0, build_record(32'h0, 32'd9, {24'h0, lbrs_pkg::SLOT_B}));
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd9, {24'h0, 8'h43}));
        // upper slot bits set but slot byte valid
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd7,
                                       {24'hFF_FFFF, lbrs_pkg::SLOT_A}));
        send_record(1'b0, build_record(32'hFFFF_FFFE, 32'd9, {24'h0, lbrs_pkg::SLOT_A}));
        // erased record stops the scan, later records ignored
        send_record(1'b0, erased_record());
        send_record(1'b0, build_record(lbrs_pkg::LOG_MAGIC, 32'd100,
                                       {24'h0, lbrs_pkg::SLOT_B}));
        // restart straight onto an erased record: nothing found
        send_record(1'b1, erased_record());
        send_record(1'b1, build_record(lbrs_pkg::LOG_MAGIC, 32'd0, {24'h0, lbrs_pkg::SLOT_B}));
        send_record(1'b0, '0);
        rec     = build_record(lbrs_pkg::LOG_MAGIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        rec.crc = 32'hFFFF_FFFF;
        send_record(1'b0, rec);
        send_record(1'b0, '1);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // no idling, with one long receiver hold-off under a busy sender
        run_directed();
        hold_off_req = 64;
        send_scan(40, 1'b0);
        send_random_scans(250, 1'b1);
        drain_results();

        // sender idle about half the time
        sender_idle_pct = 51;
        send_random_scans(250, 1'b0);
        drain_results();

        // receiver stalling about half the time
        sender_idle_pct    = 0;
        receiver_stall_pct = 51;
        send_random_scans(250, 1'b0);
        drain_results();

        // both sides idling
        sender_idle_pct    = 33;
        receiver_stall_pct = 33;
        send_random_scans(250, 1'b1);
        drain_results();

        repeat (10) @(posedge aclk);
        if (scan_board.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
